// ===== sv/tss_pkg.sv =====
package tss_pkg;

    // Default geometry
    localparam int CHANNELS_DEF    = 4;
    localparam int STEPS_DEF       = 16;
    localparam int PHRASES_DEF     = 16;
    localparam int SONG_LENGTH_DEF = 16;

    // Step field carried in a queued command; covers the largest phrase length (64)
    localparam int STEP_FIELD_W = 6;
    // Field widths fixed by the word format
    localparam int FIELD4_W     = 4;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [15:0] PERIOD_RESET = 16'd9;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [7:0]  NOTE_MAX     = 8'd127;
    localparam logic [7:0]  SEMITONES    = 8'd12;

    // Register index of step_period (taken from paddr[2])
    localparam logic REG_STEP_PERIOD = 1'b0;

    typedef enum logic [1:0] {
        FN_TICK   = 2'd0,
        FN_TOGGLE = 2'd1,
        FN_SONG   = 2'd2,
        FN_PHRASE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CMD_FIRE   = 2'd0,
        CMD_SONG   = 2'd1,
        CMD_PHRASE = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_EMIT = 2'd2
    } back_state_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic [STEP_FIELD_W-1:0]   step;        // play step for a fire
        logic [1:0]                channel;     // song write channel
        logic                      ref_valid;   // song entry holds a phrase
        logic [FIELD4_W-1:0]       phrase;      // song phrase or phrase being written
        logic [FIELD4_W-1:0]       step_index;
        logic                      note_valid;
        logic [FIELD4_W-1:0]       semitone;
        logic [FIELD4_W-1:0]       octave;
        logic [1:0]                instrument;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== sv/tracker_step_sequencer.sv =====
// Channel   Dir  Handshake               Words
// s_*       in   s_tvalid / s_tready     one command word (tick, toggle, song or phrase write)
// m_*       out  m_tvalid / m_tready     one channel event word, m_tlast on the last channel
// apb       in   psel / penable / pready one register write or read (step_period at 0x0)
//
// Flow: a word that fires no step is handled in the front end, and a table write is also
// queued for the back end. A firing step leaves the command queue, then each channel takes
// a phrase RAM read and then an output register load in the back end.
// Stalls: the four-entry command queue lets the front keep accepting while the back
// end waits on m_tready; s_tready drops only when the queue is full.
// Reset: asynchronous, active low; song and phrase valid bits clear at once, so no
// clearing pass follows reset and the block accepts words as soon as reset is released.
module tracker_step_sequencer #(
    parameter int CHANNELS    = tss_pkg::CHANNELS_DEF,
    parameter int STEPS       = tss_pkg::STEPS_DEF,
    parameter int PHRASES     = tss_pkg::PHRASES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] channel_index, [5:2] song_position, [10:6] phrase_ref, [14:11] phrase number,
    // [18:15] step_index, [23:19] note, [27:24] octave, [29:28] instrument, [31:30] zero
    input  logic [31:0] s_tdata,
    // [1:0] func
    input  logic [1:0]  s_tuser,
    // event stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] out_channel, [2] gate_on, [9:3] note_number, [11:10] out_instrument, [15:12] zero
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tss_pkg::*;

    logic [15:0] step_period_reg;
    logic        cfg_wr;
    logic        push, pop;
    cmd_t        push_cmd, head;
    q_stat_t     q_stat;

    // Song positions other than 0 are never played, so the song table keeps
    // only the position-0 column; the song length stays fixed at SONG_LENGTH_DEF.

    // Register file: one register, decoded on paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STEP_PERIOD);
    assign prdata = (paddr[2] == REG_STEP_PERIOD) ? {16'b0, step_period_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_period_reg <= PERIOD_RESET;
        end
        else if (cfg_wr)
        begin
            step_period_reg <= pwdata[15:0];
        end
    end

    // Front end: count ticks, run the play state, filter writes
    tss_front #(
        .CHANNELS(CHANNELS),
        .STEPS   (STEPS),
        .PHRASES (PHRASES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .step_period(step_period_reg),
        .q_stat     (q_stat),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Command queue keeps writes and fires in order between the two halves
    tss_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .head    (head),
        .stat    (q_stat)
    );

    // Back end: apply table writes, walk the channels of a fired step
    tss_back #(
        .CHANNELS(CHANNELS),
        .PHRASES (PHRASES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .head    (head),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

// ===== sv/tss_ram.sv =====
module tss_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tss_front.sv =====
module tss_front #(
    parameter int CHANNELS = tss_pkg::CHANNELS_DEF,
    parameter int STEPS    = tss_pkg::STEPS_DEF,
    parameter int PHRASES  = tss_pkg::PHRASES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [31:0]     s_tdata,
    input  logic [1:0]      s_tuser,
    input  logic [15:0]     step_period,
    input  tss_pkg::q_stat_t q_stat,
    output logic            push,
    output tss_pkg::cmd_t   push_cmd
);
    import tss_pkg::*;

    localparam int STW = $clog2(STEPS);

    logic [15:0]    count_reg, count_next, count_inc;
    logic [STW-1:0] step_reg, step_next;
    logic           play_reg, play_next;
    logic           accept;
    func_t          fn;

    logic [1:0] channel_index;
    logic [3:0] song_position;
    logic [4:0] phrase_ref;
    logic [3:0] phrase_sel;
    logic [3:0] step_index;
    logic [4:0] note;
    logic [3:0] octave;
    logic [1:0] instrument;

    assign channel_index = s_tdata[1:0];
    assign song_position = s_tdata[5:2];
    assign phrase_ref    = s_tdata[10:6];
    assign phrase_sel    = s_tdata[14:11];
    assign step_index    = s_tdata[18:15];
    assign note          = s_tdata[23:19];
    assign octave        = s_tdata[27:24];
    assign instrument    = s_tdata[29:28];

    assign fn       = func_t'(s_tuser);
    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && !q_stat.full;
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'd1;

    always_comb
    begin
        count_next = count_reg;
        step_next  = step_reg;
        play_next  = play_reg;
        push       = 1'b0;
        push_cmd   = '0;
        push_cmd.kind       = CMD_FIRE;
        push_cmd.step       = STEP_FIELD_W'(step_reg);
        push_cmd.channel    = channel_index;
        push_cmd.ref_valid  = !phrase_ref[4] && (9'(phrase_ref[3:0]) < 9'(PHRASES));
        push_cmd.step_index = step_index;
        push_cmd.note_valid = !note[4];
        push_cmd.semitone   = note[3:0];
        push_cmd.octave     = octave;
        push_cmd.instrument = instrument;
        push_cmd.phrase     = phrase_ref[3:0];
        if (accept)
        begin
            unique case (fn)
                FN_TICK:
                begin
                    count_next = count_inc;
                    if (play_reg && count_inc >= step_period)
                    begin
                        push       = 1'b1;
                        count_next = '0;
                        step_next  = (step_reg == STW'(STEPS - 1)) ? '0 : STW'(step_reg + 1'b1);
                    end
                end
                FN_TOGGLE:
                begin
                    step_next = '0;
                    play_next = !play_reg;
                end
                FN_SONG:
                begin
                    // only song position 0 is ever played; drop the rest
                    push_cmd.kind = CMD_SONG;
                    push = (5'(channel_index) < 5'(CHANNELS)) && (song_position == '0);
                end
                FN_PHRASE:
                begin
                    push_cmd.kind   = CMD_PHRASE;
                    push_cmd.phrase = phrase_sel;
                    push = (9'(phrase_sel) < 9'(PHRASES)) && (7'(step_index) < 7'(STEPS));
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            step_reg  <= '0;
            play_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            step_reg  <= step_next;
            play_reg  <= play_next;
        end
    end

endmodule

// ===== sv/tss_queue.sv =====
module tss_queue #(
    parameter int DEPTH = tss_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tss_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output tss_pkg::cmd_t    head,
    output tss_pkg::q_stat_t stat
);
    import tss_pkg::*;

    localparam int PW = $clog2(DEPTH);

    cmd_t        entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   fill_reg;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (fill_reg == (PW + 1)'(DEPTH));
    assign stat.empty = (fill_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
            end
            unique case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

// ===== sv/tss_back.sv =====
module tss_back #(
    parameter int CHANNELS = tss_pkg::CHANNELS_DEF,
    parameter int PHRASES  = tss_pkg::PHRASES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tss_pkg::q_stat_t q_stat,
    input  tss_pkg::cmd_t    head,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,
    output logic             m_tlast
);
    import tss_pkg::*;

    // Writable phrase rows; the phrase field is four bits wide
    localparam int PH_ROWS = (PHRASES < 16) ? PHRASES : 16;
    localparam int PHW     = (PH_ROWS > 1) ? $clog2(PH_ROWS) : 1;
    localparam int AW      = PHW + FIELD4_W;
    localparam int DEPTH   = 1 << AW;
    localparam int CHW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RW      = 3 * FIELD4_W - 2;

    back_state_t state_reg, state_next;
    logic [CHW-1:0] ch_reg, ch_next;
    logic [STEP_FIELD_W-1:0] step_q_reg;
    logic hit_reg, hit_next;

    logic             song_valid_reg [CHANNELS];
    logic [PHW-1:0]   song_phrase_reg [CHANNELS];
    logic [DEPTH-1:0] pv_reg;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [RW-1:0] ram_wr_data, ram_rd_data;
    logic          song_wr, fire_take, load_out, last_ch;

    logic       out_valid_reg;
    logic [1:0] out_channel_reg, out_instrument_reg;
    logic       gate_on_reg, last_reg;
    logic [6:0] note_number_reg;
    logic [7:0] note_sum;
    logic [6:0] note_sat;

    assign ram_wr_addr = {head.phrase[PHW-1:0], head.step_index};
    assign ram_wr_data = {head.semitone, head.octave, head.instrument};
    assign ram_rd_addr = {song_phrase_reg[ch_reg], step_q_reg[FIELD4_W-1:0]};
    assign last_ch     = (ch_reg == CHW'(CHANNELS - 1));

    tss_ram #(
        .WIDTH(RW),
        .DEPTH(DEPTH)
    ) u_phrase_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign note_sum = 8'(ram_rd_data[5:2]) * SEMITONES + 8'(ram_rd_data[9:6]);
    assign note_sat = (note_sum > NOTE_MAX) ? NOTE_MAX[6:0] : note_sum[6:0];

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        hit_next   = hit_reg;
        pop        = 1'b0;
        ram_wr_en  = 1'b0;
        song_wr    = 1'b0;
        fire_take  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    unique case (head.kind)
                        CMD_FIRE:
                        begin
                            fire_take  = 1'b1;
                            ch_next    = '0;
                            state_next = BK_READ;
                        end
                        CMD_SONG:   song_wr   = 1'b1;
                        CMD_PHRASE: ram_wr_en = 1'b1;
                        default:    ;
                    endcase
                end
            end
            BK_READ:
            begin
                // steps beyond the writable range are always empty
                hit_next = song_valid_reg[ch_reg]
                        && (step_q_reg[STEP_FIELD_W-1:FIELD4_W] == '0)
                        && pv_reg[ram_rd_addr];
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out = 1'b1;
                    if (last_ch)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        ch_next    = CHW'(ch_reg + 1'b1);
                        state_next = BK_READ;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            ch_reg        <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            pv_reg        <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                song_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            hit_reg   <= hit_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ram_wr_en)
            begin
                pv_reg[ram_wr_addr] <= head.note_valid;
            end
            if (song_wr)
            begin
                song_valid_reg[CHW'(head.channel)] <= head.ref_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire_take)
        begin
            step_q_reg <= head.step;
        end
        if (song_wr)
        begin
            song_phrase_reg[CHW'(head.channel)] <= head.phrase[PHW-1:0];
        end
        if (load_out)
        begin
            out_channel_reg    <= 2'(ch_reg);
            gate_on_reg        <= hit_reg;
            note_number_reg    <= hit_reg ? note_sat : '0;
            out_instrument_reg <= hit_reg ? ram_rd_data[1:0] : '0;
            last_reg           <= last_ch;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0, out_instrument_reg, note_number_reg, gate_on_reg, out_channel_reg};

endmodule

// ===== sv/tss_checker.sv =====
module tss_checker #(
    parameter int CHANNELS = tss_pkg::CHANNELS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // Hold a stalled event word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("event word changed while stalled");

    // Mark only the final channel as last
    a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[1:0] == 2'(CHANNELS - 1))
        else $error("last flag on wrong channel");

    // Release-only events carry no note or instrument
    a_release_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[11:3] == '0)
        else $error("release event carries note data");

    // Advance channel by one after a non-final event is taken
    a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid
        |-> m_tdata[1:0] == 2'($past(m_tdata[1:0]) + 2'd1) || $past(m_tvalid, 1) == 1'b0)
        else $error("channel events out of order");

endmodule

bind tracker_step_sequencer tss_checker #(
    .CHANNELS(CHANNELS)
) u_tss_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

// ===== sim/testbench.sv =====
module testbench;
    import tss_pkg::*;

    localparam int CH_N         = CHANNELS_DEF;
    localparam int STEP_N       = STEPS_DEF;
    localparam int PHRASE_N     = PHRASES_DEF;
    localparam int SONG_N       = SONG_LENGTH_DEF;
    // Margin for a firing step to drain through the back end after its events arrive.
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 35;
    // Period and tick count for the stopped-count test.
    localparam logic [15:0] STOP_PERIOD = 16'd40;
    localparam int          STOP_TICKS  = 45;

    // Register byte addresses; paddr[2] selects the register.
    localparam logic [2:0] ADDR_STEP_PERIOD = {REG_STEP_PERIOD, 2'b00};
    localparam logic [2:0] ADDR_NO_REG      = {~REG_STEP_PERIOD, 2'b00};

    // One command word as it travels on s_tdata/s_tuser.
    typedef struct packed {
        func_t       fn;
        logic [1:0]  chan;
        logic [3:0]  pos;
        logic [4:0]  pref;
        logic [3:0]  phr;
        logic [3:0]  stp;
        logic [4:0]  note;
        logic [3:0]  oct;
        logic [1:0]  ins;
    } seq_word_t;

    // One channel event as it travels on m_tdata/m_tlast.
    typedef struct packed {
        logic [1:0] chan;
        logic       gate;
        logic [6:0] num;
        logic [1:0] ins;
        logic       last;
    } chan_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = FN_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tracker_step_sequencer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Mirror of the sequencer state, kept in step with every accepted word.
    logic        song_ok   [CH_N][SONG_N];
    logic [3:0]  song_phr  [CH_N][SONG_N];
    logic        step_ok   [PHRASE_N][STEP_N];
    logic [3:0]  step_semi [PHRASE_N][STEP_N];
    logic [3:0]  step_oct  [PHRASE_N][STEP_N];
    logic [1:0]  step_ins  [PHRASE_N][STEP_N];
    logic [15:0] ticks;
    logic [3:0]  play_step;
    bit          playing;
    logic [15:0] period;

    // Channel events still owed by the block, oldest first.
    chan_event_t due_events[$];

    int errors         = 0;
    int words_sent     = 0;
    int events_checked = 0;
    int steps_fired    = 0;
    int reg_writes     = 0;
    int stall_cycles   = 0;
    int cycle_count    = 0;

    // Idle controls: random bursts on the sender and receiver, and a long
    // hold-off on the receiver requested by the pressure test.
    bit gaps_on   = 1'b0;
    bit stalls_on = 1'b0;
    int hold_req  = 0;
    int hold_left = 0;
    int stall_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cycle limit reached with %0d events outstanding", due_events.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // Receiver: drive m_tready at the falling edge. A hold-off request wins
    // over random bursts; with bursts off, take every word.
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Checker: compare each accepted event word with the oldest expectation.
    chan_event_t want;
    chan_event_t got;
    always @(posedge clk)
    begin
        if (s_tvalid && !s_tready)
            stall_cycles++;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{chan: m_tdata[1:0], gate: m_tdata[2], num: m_tdata[9:3],
                    ins: m_tdata[11:10], last: m_tlast};
            if (due_events.size() == 0)
            begin
                $error("event word with nothing expected: channel %0d gate %0d note %0d",
                       got.chan, got.gate, got.num);
                errors++;
            end
            else
            begin
                want = due_events.pop_front();
                events_checked++;
                if (got.chan !== want.chan)
                begin
                    $error("out_channel expected %0d got %0d", want.chan, got.chan);
                    errors++;
                end
                if (got.gate !== want.gate)
                begin
                    $error("gate_on expected %0d got %0d", want.gate, got.gate);
                    errors++;
                end
                if (got.num !== want.num)
                begin
                    $error("note_number expected %0d got %0d", want.num, got.num);
                    errors++;
                end
                if (got.ins !== want.ins)
                begin
                    $error("out_instrument expected %0d got %0d", want.ins, got.ins);
                    errors++;
                end
                if (got.last !== want.last)
                begin
                    $error("last expected %0d got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // Return the mirror to its reset state: tables empty, stopped, period 9.
    task automatic clear_mirror();
        for (int c = 0; c < CH_N; c++)
            for (int p = 0; p < SONG_N; p++)
            begin
                song_ok[c][p]  = 1'b0;
                song_phr[c][p] = '0;
            end
        for (int f = 0; f < PHRASE_N; f++)
            for (int s = 0; s < STEP_N; s++)
            begin
                step_ok[f][s]   = 1'b0;
                step_semi[f][s] = '0;
                step_oct[f][s]  = '0;
                step_ins[f][s]  = '0;
            end
        ticks     = '0;
        play_step = '0;
        playing   = 1'b0;
        period    = PERIOD_RESET;
    endtask

    // Advance the mirror by one accepted word and queue the events it fires.
    task automatic apply_word(input seq_word_t w);
        chan_event_t ev;
        logic [3:0]  ph;
        int          num;
        case (w.fn)
            FN_TICK:
            begin
                // Count saturates; it keeps running while stopped.
                if (ticks != COUNT_MAX)
                    ticks++;
                if (playing && ticks >= period)
                begin
                    for (int ch = 0; ch < CH_N; ch++)
                    begin
                        ev = '0;
                        ev.chan = ch[1:0];
                        ev.last = (ch == CH_N - 1);
                        // Playback always reads song position 0.
                        if (song_ok[ch][0])
                        begin
                            ph = song_phr[ch][0];
                            if (step_ok[ph][play_step])
                            begin
                                num = int'(step_oct[ph][play_step]) * int'(SEMITONES)
                                      + int'(step_semi[ph][play_step]);
                                if (num > int'(NOTE_MAX))
                                    num = int'(NOTE_MAX);
                                ev.gate = 1'b1;
                                ev.num  = num[6:0];
                                ev.ins  = step_ins[ph][play_step];
                            end
                        end
                        due_events.push_back(ev);
                    end
                    steps_fired++;
                    play_step = (play_step == STEP_N - 1) ? 4'd0 : play_step + 4'd1;
                    ticks = '0;
                end
            end
            FN_TOGGLE:
            begin
                // Step restarts; the sample count is kept.
                play_step = '0;
                playing   = !playing;
            end
            FN_SONG:
            begin
                // Negative reference stores an empty entry.
                song_ok[w.chan][w.pos]  = !w.pref[4];
                song_phr[w.chan][w.pos] = w.pref[4] ? 4'd0 : w.pref[3:0];
            end
            FN_PHRASE:
            begin
                // Negative note stores no note; semitones above 11 are kept.
                step_ok[w.phr][w.stp]   = !w.note[4];
                step_semi[w.phr][w.stp] = w.note[4] ? 4'd0 : w.note[3:0];
                step_oct[w.phr][w.stp]  = w.oct;
                step_ins[w.phr][w.stp]  = w.ins;
            end
        endcase
    endtask

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input seq_word_t w);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.fn;
        s_tdata  <= {2'b00, w.ins, w.oct, w.note, w.stp, w.phr, w.pref, w.pos, w.chan};
        do
            @(posedge clk);
        while (!s_tready);
        apply_word(w);
        words_sent++;
    endtask

    // Word of the given kind with every other field random.
    function automatic seq_word_t make_word(input func_t fn);
        seq_word_t w;
        w    = seq_word_t'($urandom);
        w.fn = fn;
        return w;
    endfunction

    function automatic seq_word_t song_word(input logic [1:0] ch, input logic [3:0] pos,
                                            input logic [4:0] pref);
        seq_word_t w;
        w      = make_word(FN_SONG);
        w.chan = ch;
        w.pos  = pos;
        w.pref = pref;
        return w;
    endfunction

    function automatic seq_word_t phrase_word(input logic [3:0] phr, input logic [3:0] stp,
                                              input logic [4:0] note, input logic [3:0] oct,
                                              input logic [1:0] ins);
        seq_word_t w;
        w      = make_word(FN_PHRASE);
        w.phr  = phr;
        w.stp  = stp;
        w.note = note;
        w.oct  = oct;
        w.ins  = ins;
        return w;
    endfunction

    // Random word shaped toward playback: mostly ticks, song writes mostly at
    // position 0 with a real phrase, mostly real notes; the rest is noise.
    function automatic seq_word_t random_word();
        seq_word_t w;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            w = make_word(FN_TICK);
        else if (pick < 60)
            w = make_word(FN_TOGGLE);
        else if (pick < 78)
        begin
            w = make_word(FN_SONG);
            if ($urandom_range(0, 9) < 6)
                w.pos = '0;
            w.pref = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 15))
                                                 : 5'($urandom_range(16, 31));
        end
        else
        begin
            w = make_word(FN_PHRASE);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                w.note = 5'($urandom_range(0, 11));
            else if (pick < 85)
                w.note = 5'($urandom_range(12, 15));
            else
                w.note = 5'($urandom_range(16, 31));
            if ($urandom_range(0, 4) != 0)
                w.oct = 4'($urandom_range(0, 9));
        end
        return w;
    endfunction

    // Drop valid, wait for every owed event, then let the back end drain.
    task automatic settle_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (due_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // Unknown register indexes are ignored.
        if (addr[2] == REG_STEP_PERIOD)
            period = data[15:0];
        reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read(input logic [2:0] addr, output logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_period(input logic [15:0] value);
        settle_block();
        reg_write(ADDR_STEP_PERIOD, {16'h0000, value});
    endtask

    task automatic ensure_playing(input bit run);
        if (playing != run)
            send_word(make_word(FN_TOGGLE));
    endtask

    // Register port: reset value, full-scale write, write to a missing index.
    task automatic test_register_port();
        logic [31:0] rd;
        reg_read(ADDR_STEP_PERIOD, rd);
        if (rd[15:0] !== period)
        begin
            $error("step_period expected %0d got %0d", period, rd[15:0]);
            errors++;
        end
        reg_write(ADDR_STEP_PERIOD, 32'h0000_FFFF);
        reg_write(ADDR_NO_REG, 32'h0000_0005);
        reg_read(ADDR_STEP_PERIOD, rd);
        if (rd[15:0] !== period)
        begin
            $error("step_period expected %0d got %0d", period, rd[15:0]);
            errors++;
        end
    endtask

    // Field extremes, empty and negative references, saturating notes,
    // toggles mid-play and from stopped.
    task automatic test_directed_patterns();
        set_period(16'd1);
        send_word(song_word(2'd0, 4'd0, 5'd0));
        send_word(song_word(2'd1, 4'd0, 5'd15));
        send_word(song_word(2'd2, 4'd0, 5'b11111));
        send_word(song_word(2'd3, 4'd0, 5'b10000));
        send_word(song_word(2'd3, 4'd15, 5'd7));
        send_word(phrase_word(4'd0, 4'd0, 5'd0, 4'd0, 2'd0));
        send_word(phrase_word(4'd0, 4'd1, 5'd11, 4'd9, 2'd3));
        send_word(phrase_word(4'd0, 4'd2, 5'd15, 4'd15, 2'd1));
        send_word(phrase_word(4'd0, 4'd3, 5'b11111, 4'd5, 2'd2));
        send_word(phrase_word(4'd15, 4'd0, 5'd5, 4'd4, 2'd2));
        send_word(phrase_word(4'd15, 4'd1, 5'd12, 4'd10, 2'd3));
        send_word(phrase_word(4'd15, 4'd2, 5'd11, 4'd0, 2'd1));
        send_word(phrase_word(4'd15, 4'd15, 5'b10000, 4'd15, 2'd3));
        send_word(make_word(FN_TOGGLE));
        repeat (4) send_word(make_word(FN_TICK));
        send_word(make_word(FN_TOGGLE));
        send_word(make_word(FN_TICK));
        send_word(make_word(FN_TOGGLE));
        repeat (3) send_word(make_word(FN_TICK));
        // Empty a populated entry again.
        send_word(song_word(2'd1, 4'd0, 5'b11111));
        send_word(make_word(FN_TICK));
    endtask

    // Zero period fires on every tick while playing.
    task automatic test_zero_period();
        set_period(16'd0);
        ensure_playing(1'b1);
        repeat (6) send_word(make_word(FN_TICK));
    endtask

    // Count keeps running while stopped; once playback starts, the kept count
    // is past the period and the first tick fires at once.
    task automatic test_stopped_count();
        set_period(STOP_PERIOD);
        ensure_playing(1'b0);
        repeat (STOP_TICKS) send_word(make_word(FN_TICK));
        send_word(make_word(FN_TOGGLE));
        repeat (3) send_word(make_word(FN_TICK));
    endtask

    // Hold the receiver off while ticks keep firing so the command queue
    // fills and s_tready drops.
    task automatic test_backpressure();
        set_period(16'd0);
        ensure_playing(1'b1);
        gaps_on  = 1'b0;
        hold_req = 300;
        repeat (40) send_word(make_word(FN_TICK));
    endtask

    // Random traffic in phases, each with its own period; idling in bursts,
    // off in some phases and in the last.
    task automatic test_random_traffic();
        logic [15:0] periods [RANDOM_PHASES];
        periods = '{16'd1, 16'd2, 16'd0, 16'd3, PERIOD_RESET, 16'd1, 16'd4, 16'd2};
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_period(periods[ph]);
            gaps_on   = (ph % 3 != 2) && (ph < RANDOM_PHASES - 1);
            stalls_on = gaps_on;
            repeat (PHASE_WORDS) send_word(random_word());
        end
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
    endtask

    initial
    begin
        clear_mirror();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_port();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_directed_patterns();
        test_zero_period();
        test_stopped_count();
        stalls_on = 1'b1;
        test_backpressure();
        test_random_traffic();

        settle_block();
        if (due_events.size() != 0)
        begin
            $error("%0d channel events never arrived", due_events.size());
            errors++;
        end
        $display("covered %0d words, %0d steps fired, %0d events checked, %0d register writes",
                 words_sent, steps_fired, events_checked, reg_writes);
        $display("input stalled for %0d cycles under back pressure", stall_cycles);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
